// ----- hw/rtl/awsu_pkg.sv -----
// shared types, widths and register codes for the arq window sender
package awsu_pkg;

   // fixed field widths of the channels
   localparam int unsigned SEQ_FIELD_W = 16;
   localparam int unsigned TMO_W       = 8;
   localparam int unsigned WLIM_W      = 4;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 2'd1;

   // register reset values
   localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd8;
   localparam logic [WLIM_W-1:0] WINDOW_RESET  = 4'd8;

   // flags from the entry evaluation unit
   typedef struct packed {
      logic hit;
      logic expired;
   } eval_flags_type;

   // one result word
   typedef struct packed {
      logic                   send_valid;
      logic [SEQ_FIELD_W-1:0] send_seq;
      logic                   is_retransmit;
      logic                   ack_matched;
      logic                   last_of_tick;
   } rsp_word_type;

   // index width for a store of the given depth, at least one bit
   function automatic int unsigned idx_width(input int unsigned depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ----- hw/rtl/awsu_channels.sv -----
// valid/ready channel interfaces for tick input, result output and csr writes

interface awsu_req_if;
   logic                                valid;
   logic                                ready;
   logic                                ack_present;
   logic [awsu_pkg::SEQ_FIELD_W-1:0]    ack_seq;
   modport source (output valid, output ack_present, output ack_seq, input ready);
   modport sink   (input valid, input ack_present, input ack_seq, output ready);
endinterface

interface awsu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                send_valid;
   logic [awsu_pkg::SEQ_FIELD_W-1:0]    send_seq;
   logic                                is_retransmit;
   logic                                ack_matched;
   logic                                last_of_tick;
   modport source (output valid, output send_valid, output send_seq, output is_retransmit,
                   output ack_matched, output last_of_tick, input ready);
   modport sink   (input valid, input send_valid, input send_seq, input is_retransmit,
                   input ack_matched, input last_of_tick, output ready);
endinterface

interface awsu_csr_if;
   logic                                valid;
   logic                                ready;
   logic [awsu_pkg::CSR_IDX_W-1:0]      index;
   logic [awsu_pkg::CSR_DATA_W-1:0]     wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/awsu_ram.sv -----
// simple dual-port store: one write port, one registered read port
module awsu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [awsu_pkg::idx_width(DEPTH)-1:0]      wr_idx,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [awsu_pkg::idx_width(DEPTH)-1:0]      rd_idx,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/awsu_entry_eval.sv -----
// shared entry unit: ack compare, expiry test and saturating life decrement
module awsu_entry_eval #(
   parameter int unsigned SEQ_WIDTH  = 16,
   parameter int unsigned LIFE_WIDTH = 8
) (
   input  logic                            ack_check,
   input  logic [SEQ_WIDTH-1:0]            ack_seq,
   input  logic [SEQ_WIDTH-1:0]            op_seq,
   input  logic [LIFE_WIDTH-1:0]           op_life,
   output awsu_pkg::eval_flags_type        flags,
   output logic [LIFE_WIDTH-1:0]           life_dec
);

   logic life_zero;

   assign life_zero = (op_life == '0);

   // compare and expiry
   assign flags.hit     = ack_check && (op_seq == ack_seq);
   assign flags.expired = life_zero;

   // count down, stopping at zero
   assign life_dec = life_zero ? '0 : (op_life - LIFE_WIDTH'(1));

endmodule

// ----- hw/rtl/arq_window_sender_unit.sv -----
// top level of the arq window sender: sequencer, list stores and result register
//
//  channel   dir   handshake        word
//  req_ch    in    valid/ready      ack_present, ack_seq (one timer tick)
//  rsp_ch    out   valid/ready      send_valid, send_seq, is_retransmit, ack_matched,
//                                   last_of_tick (one or more per tick)
//  csr_ch    in    valid/ready      index, wdata (0 timeout_ticks, 1 window_limit)
//
// with no output stall a tick walks its n list entries once through the shared entry
// unit at one per cycle, reads its r resends back one at a time from the resend store,
// then makes the new send and returns to idle; the single read port of each store
// sets this pace
// req_ch.ready is high only while idle; csr writes are always taken
// a result waits in the output register while rsp_ch is stalled, and the
// sequencer holds before loading the next result; reset is synchronous, active high
module arq_window_sender_unit #(
   parameter int unsigned WINDOW_DEPTH = 8,
   parameter int unsigned SEQ_WIDTH    = 16,
   parameter int unsigned LIFE_WIDTH   = 8
) (
   input  logic       clock,
   input  logic       reset,
   awsu_req_if.sink   req_ch,
   awsu_rsp_if.source rsp_ch,
   awsu_csr_if.sink   csr_ch
);

   localparam int unsigned IDX_W   = awsu_pkg::idx_width(WINDOW_DEPTH);
   localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned ENTRY_W = SEQ_WIDTH + LIFE_WIDTH;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_RFETCH = 3'd2;
   localparam logic [2:0] S_RLOAD  = 3'd3;
   localparam logic [2:0] S_NEW    = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [awsu_pkg::TMO_W-1:0]       timeout_ff;
   logic [awsu_pkg::WLIM_W-1:0]      window_ff;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [SEQ_WIDTH-1:0]             next_seq_ff, next_seq_in;
   logic                             ack_present_ff, ack_present_in;
   logic [SEQ_WIDTH-1:0]             ack_seq_ff, ack_seq_in;
   logic                             matched_ff, matched_in;
   logic [CNT_W-1:0]                 rd_cnt_ff, rd_cnt_in;
   logic                             pend_ff, pend_in;
   logic [CNT_W-1:0]                 w_ff, w_in;
   logic [CNT_W-1:0]                 r_ff, r_in;
   logic                             out_valid_ff, out_valid_in;
   awsu_pkg::rsp_word_type           out_ff, out_in;

   // store ports
   logic                             list_wr_en, list_rd_en;
   logic [IDX_W-1:0]                 list_wr_idx, list_rd_idx;
   logic [ENTRY_W-1:0]               list_wr_data, list_rd_data;
   logic                             res_wr_en, res_rd_en;
   logic [IDX_W-1:0]                 res_wr_idx, res_rd_idx;
   logic [SEQ_WIDTH-1:0]             res_rd_data;

   // shared unit ports
   logic [SEQ_WIDTH-1:0]             op_seq;
   logic [LIFE_WIDTH-1:0]            op_life;
   awsu_pkg::eval_flags_type         flags;
   logic [LIFE_WIDTH-1:0]            life_dec;

   logic [LIFE_WIDTH-1:0]            tmo;
   logic [CNT_W-1:0]                 limit;
   logic [CNT_W-1:0]                 total;
   logic                             room;
   logic [CNT_W-1:0]                 rd_cnt_inc;

   assign tmo        = LIFE_WIDTH'(timeout_ff);
   assign limit      = (32'(window_ff) > WINDOW_DEPTH) ? CNT_W'(WINDOW_DEPTH)
                                                        : CNT_W'(window_ff);
   assign total      = w_ff + r_ff;
   assign room       = (total < limit);
   assign rd_cnt_inc = rd_cnt_ff + CNT_W'(1);

   // list store: sequence number over remaining life
   awsu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_idx  (list_wr_idx),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_idx  (list_rd_idx),
      .rd_data (list_rd_data)
   );

   // resend store: expired sequence numbers in list order
   awsu_ram #(
      .WIDTH (SEQ_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_resend_ram (
      .clock   (clock),
      .wr_en   (res_wr_en),
      .wr_idx  (res_wr_idx),
      .wr_data (list_rd_data[ENTRY_W-1:LIFE_WIDTH]),
      .rd_en   (res_rd_en),
      .rd_idx  (res_rd_idx),
      .rd_data (res_rd_data)
   );

   // shared unit operands: list entry while scanning, timeout on reload
   always_comb begin
      op_seq  = list_rd_data[ENTRY_W-1:LIFE_WIDTH];
      op_life = list_rd_data[LIFE_WIDTH-1:0];
      if (state_ff == S_RLOAD) begin
         op_seq  = res_rd_data;
         op_life = tmo;
      end
   end

   awsu_entry_eval #(
      .SEQ_WIDTH  (SEQ_WIDTH),
      .LIFE_WIDTH (LIFE_WIDTH)
   ) u_entry_eval (
      .ack_check (ack_present_ff && !matched_ff),
      .ack_seq   (ack_seq_ff),
      .op_seq    (op_seq),
      .op_life   (op_life),
      .flags     (flags),
      .life_dec  (life_dec)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      next_seq_in    = next_seq_ff;
      ack_present_in = ack_present_ff;
      ack_seq_in     = ack_seq_ff;
      matched_in     = matched_ff;
      rd_cnt_in      = rd_cnt_ff;
      pend_in        = pend_ff;
      w_in           = w_ff;
      r_in           = r_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_in         = out_ff;
      list_wr_en     = 1'b0;
      list_wr_idx    = w_ff[IDX_W-1:0];
      list_wr_data   = {op_seq, life_dec};
      list_rd_en     = 1'b0;
      list_rd_idx    = rd_cnt_ff[IDX_W-1:0];
      res_wr_en      = 1'b0;
      res_wr_idx     = r_ff[IDX_W-1:0];
      res_rd_en      = 1'b0;
      res_rd_idx     = rd_cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               ack_present_in = req_ch.ack_present;
               ack_seq_in     = SEQ_WIDTH'(req_ch.ack_seq);
               matched_in     = 1'b0;
               rd_cnt_in      = '0;
               pend_in        = 1'b0;
               w_in           = '0;
               r_in           = '0;
               state_in       = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue the next read while the previous entry is evaluated
            pend_in = 1'b0;
            if (rd_cnt_ff < count_ff) begin
               list_rd_en = 1'b1;
               rd_cnt_in  = rd_cnt_inc;
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               priority if (flags.hit) begin
                  matched_in = 1'b1;
               end else if (flags.expired) begin
                  res_wr_en = 1'b1;
                  r_in      = r_ff + CNT_W'(1);
               end else begin
                  list_wr_en = 1'b1;
                  w_in       = w_ff + CNT_W'(1);
               end
            end
            if ((rd_cnt_ff == count_ff) && !pend_ff) begin
               rd_cnt_in = '0;
               state_in  = S_RFETCH;
            end
         end

         S_RFETCH: begin
            if (rd_cnt_ff == r_ff) begin
               state_in = S_NEW;
            end else begin
               res_rd_en = 1'b1;
               state_in  = S_RLOAD;
            end
         end

         S_RLOAD: begin
            // append the resend to the list end and emit it
            if (!out_valid_in) begin
               list_wr_en           = 1'b1;
               list_wr_idx          = total[IDX_W-1:0] - r_ff[IDX_W-1:0]
                                      + rd_cnt_ff[IDX_W-1:0];
               out_valid_in         = 1'b1;
               out_in.send_valid    = 1'b1;
               out_in.send_seq      = awsu_pkg::SEQ_FIELD_W'(res_rd_data);
               out_in.is_retransmit = 1'b1;
               out_in.ack_matched   = matched_ff;
               out_in.last_of_tick  = (rd_cnt_inc == r_ff) && !room;
               rd_cnt_in            = rd_cnt_inc;
               state_in             = S_RFETCH;
            end
         end

         S_NEW: begin
            if (!out_valid_in) begin
               count_in = total;
               if (room) begin
                  list_wr_en           = 1'b1;
                  list_wr_idx          = total[IDX_W-1:0];
                  list_wr_data         = {next_seq_ff, tmo};
                  count_in             = total + CNT_W'(1);
                  next_seq_in          = next_seq_ff + SEQ_WIDTH'(1);
                  out_valid_in         = 1'b1;
                  out_in.send_valid    = 1'b1;
                  out_in.send_seq      = awsu_pkg::SEQ_FIELD_W'(next_seq_ff);
                  out_in.is_retransmit = 1'b0;
                  out_in.ack_matched   = matched_ff;
                  out_in.last_of_tick  = 1'b1;
               end else if (r_ff == '0) begin
                  // nothing sent this tick: one empty word
                  out_valid_in         = 1'b1;
                  out_in.send_valid    = 1'b0;
                  out_in.send_seq      = '0;
                  out_in.is_retransmit = 1'b0;
                  out_in.ack_matched   = matched_ff;
                  out_in.last_of_tick  = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_seq_ff  <= '0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // working registers of the current tick
   always_ff @(posedge clock) begin
      ack_present_ff <= ack_present_in;
      ack_seq_ff     <= ack_seq_in;
      matched_ff     <= matched_in;
      rd_cnt_ff      <= rd_cnt_in;
      w_ff           <= w_in;
      r_ff           <= r_in;
      out_ff         <= out_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= awsu_pkg::TIMEOUT_RESET;
         window_ff  <= awsu_pkg::WINDOW_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            awsu_pkg::CSR_TIMEOUT: timeout_ff <= csr_ch.wdata;
            awsu_pkg::CSR_WINDOW:  window_ff  <= awsu_pkg::WLIM_W'(csr_ch.wdata);
            default: begin
            end
         endcase
      end
   end

   // channel outputs
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.send_valid    = out_ff.send_valid;
   assign rsp_ch.send_seq      = out_ff.send_seq;
   assign rsp_ch.is_retransmit = out_ff.is_retransmit;
   assign rsp_ch.ack_matched   = out_ff.ack_matched;
   assign rsp_ch.last_of_tick  = out_ff.last_of_tick;

endmodule

// ----- tb/arq_window_sender_unit_test.sv -----
// self-checking testbench for the arq window sender: directed and random ticks, predicted results
`timescale 1ns / 1ps

module arq_window_sender_unit_test;

   localparam int unsigned LIST_DEPTH    = 8;
   localparam int unsigned RESET_CYCLES  = 3;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned PHASE_ITEMS   = 60;
   localparam int unsigned PHASE_COUNT   = 6;
   localparam int unsigned REPORT_MAX    = 10;

   // timeout and window settings of the random phases, extremes included
   localparam int unsigned PHASE_TIMEOUT [PHASE_COUNT] = '{4, 0, 255, 1, 2, 6};
   localparam int unsigned PHASE_WINDOW  [PHASE_COUNT] = '{8, 15, 1, 5, 0, 8};

   // one waiting packet in the send window
   typedef struct packed {
      logic [awsu_pkg::SEQ_FIELD_W-1:0] seq;
      logic [awsu_pkg::TMO_W-1:0]       life;
   } window_entry_type;

   // window state mirror and the words each tick should produce
   class send_ledger;
      window_entry_type                  entries[$];
      awsu_pkg::rsp_word_type            due_words[$];
      logic [awsu_pkg::SEQ_FIELD_W-1:0]  next_seq_num;
      logic [awsu_pkg::TMO_W-1:0]        timeout_val;
      logic [awsu_pkg::WLIM_W-1:0]       window_val;
      int unsigned                       failures;
      int unsigned                       ticks, words, resends, fresh_sends, acks_hit;
      int unsigned                       silent_ticks;

      function new();
         next_seq_num = '0;
         timeout_val  = awsu_pkg::TIMEOUT_RESET;
         window_val   = awsu_pkg::WINDOW_RESET;
         failures     = 0;
         ticks        = 0;
         words        = 0;
         resends      = 0;
         fresh_sends  = 0;
         acks_hit     = 0;
         silent_ticks = 0;
      endfunction

      function void set_reg(logic [awsu_pkg::CSR_IDX_W-1:0] idx,
                            logic [awsu_pkg::CSR_DATA_W-1:0] data);
         if (idx == awsu_pkg::CSR_TIMEOUT)
            timeout_val = data[awsu_pkg::TMO_W-1:0];
         else if (idx == awsu_pkg::CSR_WINDOW)
            window_val = data[awsu_pkg::WLIM_W-1:0];
      endfunction

      function int unsigned pending();
         return due_words.size();
      endfunction

      function int unsigned list_size();
         return entries.size();
      endfunction

      // sequence number of a live entry, wrapping over the list
      function logic [awsu_pkg::SEQ_FIELD_W-1:0] live_seq(int unsigned k);
         if (entries.size() == 0)
            return awsu_pkg::SEQ_FIELD_W'($urandom);
         return entries[k % entries.size()].seq;
      endfunction

      // a number issued shortly before, possibly acknowledged already
      function logic [awsu_pkg::SEQ_FIELD_W-1:0] recent_seq();
         return next_seq_num - awsu_pkg::SEQ_FIELD_W'(1 + $urandom_range(0, 3));
      endfunction

      function void queue_word(logic v, logic [awsu_pkg::SEQ_FIELD_W-1:0] s, logic r,
                               logic m);
         awsu_pkg::rsp_word_type w;
         w.send_valid    = v;
         w.send_seq      = s;
         w.is_retransmit = r;
         w.ack_matched   = m;
         w.last_of_tick  = 1'b0;
         due_words.push_back(w);
      endfunction

      // ack removal, countdown, resends to the tail, then a new send if room
      function void note_tick(logic ap, logic [awsu_pkg::SEQ_FIELD_W-1:0] ack);
         window_entry_type kept[$];
         window_entry_type expired[$];
         window_entry_type e;
         int               hit_at;
         logic             hit;
         int unsigned      cap;
         int unsigned      first_word;
         hit_at = -1;
         first_word = due_words.size();
         ticks++;
         if (ap) begin
            foreach (entries[i])
               if (hit_at < 0 && entries[i].seq == ack)
                  hit_at = i;
         end
         hit = (hit_at >= 0);
         if (hit) begin
            entries.delete(hit_at);
            acks_hit++;
         end
         foreach (entries[i]) begin
            if (entries[i].life != '0) begin
               e.seq  = entries[i].seq;
               e.life = entries[i].life - 1'b1;
               kept.push_back(e);
            end else begin
               expired.push_back(entries[i]);
            end
         end
         entries = kept;
         foreach (expired[i]) begin
            e.seq  = expired[i].seq;
            e.life = (timeout_val != '0) ? timeout_val - 1'b1 : '0;
            entries.push_back(e);
            queue_word(1'b1, e.seq, 1'b1, hit);
            resends++;
         end
         cap = (window_val > LIST_DEPTH) ? LIST_DEPTH : window_val;
         if (entries.size() < cap) begin
            e.seq  = next_seq_num;
            e.life = timeout_val;
            entries.push_back(e);
            queue_word(1'b1, next_seq_num, 1'b0, hit);
            next_seq_num = next_seq_num + 1'b1;
            fresh_sends++;
         end
         if (due_words.size() == first_word) begin
            queue_word(1'b0, '0, 1'b0, hit);
            silent_ticks++;
         end
         due_words[due_words.size()-1].last_of_tick = 1'b1;
      endfunction

      // compare one accepted word with the oldest expectation
      function void check_word(awsu_pkg::rsp_word_type got);
         awsu_pkg::rsp_word_type want;
         words++;
         if (due_words.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected word: valid %0b seq %h retx %0b matched %0b last %0b",
                        got.send_valid, got.send_seq, got.is_retransmit,
                        got.ack_matched, got.last_of_tick);
            return;
         end
         want = due_words.pop_front();
         if (got.send_valid !== want.send_valid || got.send_seq !== want.send_seq ||
             got.is_retransmit !== want.is_retransmit ||
             got.ack_matched !== want.ack_matched ||
             got.last_of_tick !== want.last_of_tick) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("mismatch: expected valid %0b seq %h retx %0b matched %0b last %0b",
                        want.send_valid, want.send_seq, want.is_retransmit,
                        want.ack_matched, want.last_of_tick);
               $display("          got      valid %0b seq %h retx %0b matched %0b last %0b",
                        got.send_valid, got.send_seq, got.is_retransmit,
                        got.ack_matched, got.last_of_tick);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   int unsigned            cycle_count = 0;
   int unsigned            burst_left = 0;
   int unsigned            hold_requests = 0;
   int unsigned            reg_writes = 0;
   awsu_pkg::rsp_word_type seen_word;
   send_ledger             ledger = new();

   awsu_req_if req_ch();
   awsu_rsp_if rsp_ch();
   awsu_csr_if csr_ch();

   arq_window_sender_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count, ledger.pending());
         $display("arq_window_sender_unit_test: FAIL");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_word.send_valid    = rsp_ch.send_valid;
         seen_word.send_seq      = rsp_ch.send_seq;
         seen_word.is_retransmit = rsp_ch.is_retransmit;
         seen_word.ack_matched   = rsp_ch.ack_matched;
         seen_word.last_of_tick  = rsp_ch.last_of_tick;
         ledger.check_word(seen_word);
      end
   end

   // receiver: stall pattern changes every so often, long hold-off on request
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned served;
      int unsigned beat;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      served = 0;
      beat = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         beat++;
         if (served != hold_requests && hold_left == 0) begin
            served++;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (beat % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // one register write on the csr channel
   task automatic write_reg(logic [awsu_pkg::CSR_IDX_W-1:0] idx,
                            logic [awsu_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      ledger.set_reg(idx, data);
      reg_writes++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every due word, then let the block wind down
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new timeout and window, written while idle; upper window bits are junk
   task automatic apply_setting(logic [awsu_pkg::TMO_W-1:0] tmo,
                                logic [awsu_pkg::WLIM_W-1:0] win);
      logic [awsu_pkg::CSR_DATA_W-awsu_pkg::WLIM_W-1:0] junk;
      junk = (awsu_pkg::CSR_DATA_W-awsu_pkg::WLIM_W)'(
                $urandom_range(0, 2**(awsu_pkg::CSR_DATA_W-awsu_pkg::WLIM_W) - 1));
      settle();
      write_reg(awsu_pkg::CSR_TIMEOUT, tmo);
      write_reg(awsu_pkg::CSR_WINDOW, {junk, win});
   endtask

   // offer one tick word, in bursts with random gaps between them
   task automatic drive_tick(logic ap, logic [awsu_pkg::SEQ_FIELD_W-1:0] seq);
      int unsigned gap;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.ack_present <= ap;
      req_ch.ack_seq     <= seq;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      ledger.note_tick(ap, seq);
   endtask

   initial begin
      int unsigned                      r;
      logic                             ap;
      logic [awsu_pkg::SEQ_FIELD_W-1:0] seq;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.ack_present = 1'b0;
      req_ch.ack_seq = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = awsu_pkg::CSR_TIMEOUT;
      csr_ch.wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short timeout, window above depth: ignored ack field, hit, miss, expiry
      apply_setting(8'd2, 4'd15);
      drive_tick(1'b0, 16'hFFFF);
      drive_tick(1'b1, 16'h0000);
      drive_tick(1'b0, 16'h0000);
      drive_tick(1'b0, 16'h5A5A);
      drive_tick(1'b0, 16'hA5A5);
      drive_tick(1'b1, 16'hFFFF);
      drive_tick(1'b1, ledger.live_seq(2));
      drive_tick(1'b0, 16'h0000);

      // zero timeout and zero window: resend every tick, drain, then nothing to send
      apply_setting(8'd0, 4'd0);
      repeat (3) drive_tick(1'b0, 16'h0000);
      while (ledger.list_size() != 0)
         drive_tick(1'b1, ledger.live_seq(0));
      drive_tick(1'b1, 16'h0001);

      // longest timeout, window of one: full window gives an empty tick
      apply_setting(8'd255, 4'd1);
      drive_tick(1'b0, 16'h1234);
      drive_tick(1'b0, 16'h0000);
      drive_tick(1'b1, ledger.live_seq(0));
      drive_tick(1'b1, 16'hFFFF);

      // random phases, mostly acks of live entries
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_setting(awsu_pkg::TMO_W'(PHASE_TIMEOUT[p]),
                       awsu_pkg::WLIM_W'(PHASE_WINDOW[p]));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 5)
               hold_requests++;
            r = $urandom_range(0, 99);
            if (r < 55 && ledger.list_size() != 0) begin
               ap = 1'b1;
               seq = ledger.live_seq($urandom_range(0, LIST_DEPTH - 1));
            end else if (r < 70) begin
               ap = 1'b0;
               seq = awsu_pkg::SEQ_FIELD_W'($urandom);
            end else if (r < 85) begin
               ap = 1'b1;
               seq = awsu_pkg::SEQ_FIELD_W'($urandom);
            end else if (r < 95) begin
               ap = 1'b1;
               seq = ledger.recent_seq();
            end else begin
               ap = 1'($urandom_range(0, 1));
               seq = $urandom_range(0, 1) ? '1 : '0;
            end
            drive_tick(ap, seq);
         end
      end

      settle();
      $display("ran %0d ticks over %0d register writes, %0d result words checked",
               ledger.ticks, reg_writes, ledger.words);
      $display("%0d resends, %0d new sends, %0d acks matched, %0d ticks with nothing to send",
               ledger.resends, ledger.fresh_sends, ledger.acks_hit, ledger.silent_ticks);
      if (ledger.failures == 0) begin
         $display("arq_window_sender_unit_test: PASS");
      end else begin
         $display("%0d failing words", ledger.failures);
         $display("arq_window_sender_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/awsu_pkg.sv
hw/rtl/awsu_channels.sv
hw/rtl/awsu_ram.sv
hw/rtl/awsu_entry_eval.sv
hw/rtl/arq_window_sender_unit.sv
tb/arq_window_sender_unit_test.sv
